/* rtl/cmp_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cmp_pkg
// shared widths, constants and types of the complex multiply / polar block
// ---------------------------------------------------------------------------
package cmp_pkg;

  localparam int OPERAND_WIDTH_DEFAULT = 16;
  localparam int CORDIC_STEPS_DEFAULT  = 16;

  // product parts, Q8.24
  localparam int PW = 32;
  // cordic datapath
  localparam int GUARD_BITS = 4;
  localparam int XW = 38;              // x and y, signed
  localparam int ZW = 34;              // angle accumulator, signed, 2^-30 rad units
  localparam int XLO = 19;             // low slice of x for the gain multiply
  localparam int XHI = XW - XLO;
  localparam int GW  = 24;             // gain constant width
  localparam int MW  = XLO + GW;       // partial product width

  localparam logic [GW-1:0]        GAIN_Q24 = 24'd10188014;
  localparam logic signed [ZW-1:0] PI_Q30   = 34'sd3373259426;
  localparam int                   PHW      = 16;
  localparam logic signed [PHW-1:0] PHASE_LIMIT = 16'sd25736;

  localparam logic [30:0] ARCTAN_Q30 [32] = '{
    31'd843314857, 31'd497837830, 31'd263043837, 31'd133525159, 31'd67021687,
    31'd33543516, 31'd16775851, 31'd8388437, 31'd4194283, 31'd2097149,
    31'd1048576, 31'd524288, 31'd262144, 31'd131072, 31'd65536, 31'd32768,
    31'd16384, 31'd8192, 31'd4096, 31'd2048, 31'd1024, 31'd512, 31'd256,
    31'd128, 31'd64, 31'd32, 31'd16, 31'd8, 31'd4, 31'd2, 31'd1, 31'd0
  };

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 zero;
    logic signed [PW-1:0] re;
    logic signed [PW-1:0] im;
  } cordic_t;

  typedef struct packed {
    logic    valid;
    cordic_t data;
  } cell_link_t;

endpackage

/* rtl/cmp_if.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cmp_if
// operand and result channels with valid / ready handshake
// ---------------------------------------------------------------------------
interface cmp_in_if #(
  parameter int WIDTH = cmp_pkg::OPERAND_WIDTH_DEFAULT
);
  logic                    valid;
  logic                    ready;
  logic signed [WIDTH-1:0] first_real;
  logic signed [WIDTH-1:0] first_imag;
  logic signed [WIDTH-1:0] second_real;
  logic signed [WIDTH-1:0] second_imag;

  modport source (output valid, first_real, first_imag, second_real, second_imag,
                  input ready);
  modport sink   (input valid, first_real, first_imag, second_real, second_imag,
                  output ready);
endinterface

interface cmp_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] product_real;
  logic signed [31:0] product_imag;
  logic        [31:0] magnitude;
  logic signed [15:0] phase_angle;

  modport source (output valid, product_real, product_imag, magnitude, phase_angle,
                  input ready);
  modport sink   (input valid, product_real, product_imag, magnitude, phase_angle,
                  output ready);
endinterface

/* rtl/complex_multiply_polar.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// complex_multiply_polar
// complex product with cordic magnitude and phase, fully pipelined
// ---------------------------------------------------------------------------
// stages: three front stages, one cell per step, two stages for gain and
//   output
// throughput: one item per cycle unless a low results.ready stalls it; every
//   stage holds one item and passes it on
// reset (synchronous, active high) clears only the stage valid flags
module complex_multiply_polar #(
  parameter int OPERAND_WIDTH = cmp_pkg::OPERAND_WIDTH_DEFAULT,
  parameter int CORDIC_STEPS  = cmp_pkg::CORDIC_STEPS_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  cmp_in_if.sink     operands,
  cmp_out_if.source  results
);
  import cmp_pkg::*;

  // link[i] feeds cell i; link[CORDIC_STEPS] feeds the gain stage
  cell_link_t link  [CORDIC_STEPS+1];
  logic       ready [CORDIC_STEPS+1];

  // multiply, rescale to Q8.24 with saturation, fold the left half plane
  cmp_front #(
    .OPERAND_WIDTH (OPERAND_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .operands   (operands),
    .down       (link[0]),
    .down_ready (ready[0])
  );

  // row of vectoring cells, cell i shifts by i and adds or subtracts atan(2^-i)
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
    cmp_cell #(
      .STEP (i)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .up         (link[i]),
      .up_ready   (ready[i]),
      .down       (link[i+1]),
      .down_ready (ready[i+1])
    );
  end

  // gain compensation, phase rounding, output register
  cmp_post u_post (
    .clk      (clk),
    .rst      (rst),
    .up       (link[CORDIC_STEPS]),
    .up_ready (ready[CORDIC_STEPS]),
    .results  (results)
  );

  // a zero product leaves zero magnitude and zero phase
  a_zero_product : assert property (@(posedge clk) disable iff (rst)
    results.valid && results.product_real == 0 && results.product_imag == 0
      |-> results.magnitude == 0 && results.phase_angle == 0)
    else $error("zero product with nonzero magnitude or phase");

  // phase stays within minus pi to pi
  a_phase_range : assert property (@(posedge clk) disable iff (rst)
    results.valid |-> results.phase_angle <= PHASE_LIMIT &&
                      results.phase_angle >= -PHASE_LIMIT)
    else $error("phase outside clamp range");

  // reset empties the output stage
  a_reset_clears : assert property (@(posedge clk)
    $past(rst) |-> !results.valid)
    else $error("result valid right after reset");

  // an empty output register never holds back the pipeline
  a_out_ready : assert property (@(posedge clk) disable iff (rst)
    !results.valid |-> ready[CORDIC_STEPS])
    else $error("gain stage stalled behind an empty output");

endmodule

/* rtl/cmp_front.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cmp_front
// partial products, Q8.24 rescale with saturation, half-plane pre-rotation
// ---------------------------------------------------------------------------
module cmp_front #(
  parameter int OPERAND_WIDTH = cmp_pkg::OPERAND_WIDTH_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  cmp_in_if.sink              operands,
  output cmp_pkg::cell_link_t down,
  input  logic                down_ready
);
  import cmp_pkg::*;

  localparam int W   = OPERAND_WIDTH;
  localparam int SW  = 2 * W + 1;                 // width of ac - bd
  localparam int SH  = 2 * (W - 4) - 24;          // fraction bits above Q24
  localparam int SHR = (SH > 0) ? SH : 0;
  localparam int SHL = (SH < 0) ? -SH : 0;
  localparam int EW  = (SW > 34) ? SW : 34;

  function automatic logic signed [PW-1:0] rescale(input logic signed [SW-1:0] v);
    logic signed [EW-1:0] r;
    logic        [EW-32:0] top;
    r   = (EW'(v) >>> SHR) <<< SHL;
    top = r[EW-1:31];
    if ((&top) || !(|top)) begin
      rescale = r[PW-1:0];
    end else if (r[EW-1]) begin
      rescale = {1'b1, {(PW-1){1'b0}}};
    end else begin
      rescale = {1'b0, {(PW-1){1'b1}}};
    end
  endfunction

  // stage 1: products
  logic                    v1;
  logic signed [2*W-1:0]   ac, bd, ad, bc;
  // stage 2: saturated parts
  logic                    v2;
  logic signed [PW-1:0]    re, im;

  logic load1, load2, load3;
  logic signed [XW-1:0] x0, y0;

  assign load3 = !down.valid || down_ready;
  assign load2 = !v2 || load3;
  assign load1 = !v1 || load2;
  assign operands.ready = load1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (load1) begin
      v1 <= operands.valid;
    end
    if (load1 && operands.valid) begin
      ac <= operands.first_real * operands.second_real;
      bd <= operands.first_imag * operands.second_imag;
      ad <= operands.first_real * operands.second_imag;
      bc <= operands.first_imag * operands.second_real;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (load2) begin
      v2 <= v1;
    end
    if (load2 && v1) begin
      re <= rescale(SW'(ac) - SW'(bd));
      im <= rescale(SW'(ad) + SW'(bc));
    end
  end

  assign x0 = XW'(re) <<< GUARD_BITS;
  assign y0 = XW'(im) <<< GUARD_BITS;

  always_ff @(posedge clk) begin
    if (rst) begin
      down.valid <= 1'b0;
    end else if (load3) begin
      down.valid <= v2;
    end
    if (load3 && v2) begin
      // left half plane: turn by pi first
      if (re[PW-1]) begin
        down.data.x <= -x0;
        down.data.y <= -y0;
        down.data.z <= im[PW-1] ? -PI_Q30 : PI_Q30;
      end else begin
        down.data.x <= x0;
        down.data.y <= y0;
        down.data.z <= '0;
      end
      down.data.zero <= (re == '0) && (im == '0);
      down.data.re   <= re;
      down.data.im   <= im;
    end
  end

endmodule

/* rtl/cmp_cell.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cmp_cell
// one cordic vectoring micro-rotation with its pipeline register
// ---------------------------------------------------------------------------
module cmp_cell #(
  parameter int STEP = 0
) (
  input  logic                clk,
  input  logic                rst,
  input  cmp_pkg::cell_link_t up,
  output logic                up_ready,
  output cmp_pkg::cell_link_t down,
  input  logic                down_ready
);
  import cmp_pkg::*;

  localparam logic [4:0] K = 5'(STEP);
  localparam logic signed [ZW-1:0] ATAN = $signed(ZW'(ARCTAN_Q30[K]));

  logic load;
  logic signed [XW-1:0] xs, ys;

  assign load     = !down.valid || down_ready;
  assign up_ready = load;
  assign xs = up.data.x >>> STEP;
  assign ys = up.data.y >>> STEP;

  always_ff @(posedge clk) begin
    if (rst) begin
      down.valid <= 1'b0;
    end else if (load) begin
      down.valid <= up.valid;
    end
    if (load && up.valid) begin
      // y above the axis turns clockwise
      if (up.data.y > 0) begin
        down.data.x <= up.data.x + ys;
        down.data.y <= up.data.y - xs;
        down.data.z <= up.data.z + ATAN;
      end else begin
        down.data.x <= up.data.x - ys;
        down.data.y <= up.data.y + xs;
        down.data.z <= up.data.z - ATAN;
      end
      down.data.zero <= up.data.zero;
      down.data.re   <= up.data.re;
      down.data.im   <= up.data.im;
    end
  end

endmodule

/* rtl/cmp_post.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cmp_post
// gain compensation in two partial products, phase rounding and clamp
// ---------------------------------------------------------------------------
module cmp_post (
  input  logic                clk,
  input  logic                rst,
  input  cmp_pkg::cell_link_t up,
  output logic                up_ready,
  cmp_out_if.source           results
);
  import cmp_pkg::*;

  localparam int SUMW = MW + XLO;

  logic                  vg;
  logic [MW-1:0]         p_lo, p_hi;
  logic                  mag_en;
  logic signed [PHW-1:0] phase;
  logic signed [PW-1:0]  re, im;

  logic loadg, loado;
  logic signed [ZW:0]    zr;
  logic signed [ZW-17:0] ph;
  logic [SUMW-1:0]       sum;
  logic [SUMW-29:0]      m;

  assign loado    = !results.valid || results.ready;
  assign loadg    = !vg || loado;
  assign up_ready = loadg;

  // round half up to Q3.13
  assign zr = (ZW+1)'(up.data.z) + (ZW+1)'(65536);
  assign ph = $signed(zr[ZW:17]);

  always_ff @(posedge clk) begin
    if (rst) begin
      vg <= 1'b0;
    end else if (loadg) begin
      vg <= up.valid;
    end
    if (loadg && up.valid) begin
      p_lo   <= up.data.x[XLO-1:0] * GAIN_Q24;
      p_hi   <= up.data.x[XW-1:XLO] * GAIN_Q24;
      mag_en <= !up.data.zero && (up.data.x > 0);
      re     <= up.data.re;
      im     <= up.data.im;
      if (up.data.zero) begin
        phase <= '0;
      end else if (ph > (ZW-16)'(PHASE_LIMIT)) begin
        phase <= PHASE_LIMIT;
      end else if (ph < -(ZW-16)'(PHASE_LIMIT)) begin
        phase <= -PHASE_LIMIT;
      end else begin
        phase <= ph[PHW-1:0];
      end
    end
  end

  assign sum = {p_hi, {XLO{1'b0}}} + SUMW'(p_lo) + (SUMW'(1) << 27);
  assign m   = sum[SUMW-1:28];

  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (loado) begin
      results.valid <= vg;
    end
    if (loado && vg) begin
      results.product_real <= re;
      results.product_imag <= im;
      results.phase_angle  <= phase;
      if (!mag_en) begin
        results.magnitude <= '0;
      end else if (|m[SUMW-29:32]) begin
        results.magnitude <= '1;
      end else begin
        results.magnitude <= m[31:0];
      end
    end
  end

endmodule

/* sim/complex_multiply_polar_tb.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// complex_multiply_polar_tb
// self-checking bench for the complex multiply with cordic magnitude / phase:
// operand items go in over a valid / ready channel, a scoreboard class works
// out the saturated product and its cordic polar form bit for bit, and every
// result item is compared field by field, in order, against that forecast
// ---------------------------------------------------------------------------
module complex_multiply_polar_tb;

  import cmp_pkg::*;

  localparam int OPW            = OPERAND_WIDTH_DEFAULT;
  localparam int STEPS          = CORDIC_STEPS_DEFAULT;
  // pipeline depth from operand accept to result valid
  localparam int LATENCY        = STEPS + 5;
  localparam int ITEMS_PER_RUN  = 217;
  localparam int STALL_CYCLES   = 400;
  // longest legal quiet stretch is the long receiver stall, plus margin
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int MISMATCH_SHOWN = 10;

  typedef logic signed [OPW-1:0] part_t;

  typedef struct packed {
    logic signed [31:0] re;
    logic signed [31:0] im;
    logic        [31:0] mag;
    logic signed [15:0] ph;
  } polar_t;

  // corner and special values of the q4.12 range
  localparam part_t CORNER_VALUES [8] = '{
    16'sh8000, 16'sh7FFF, 16'sh0000, 16'shFFFF,
    16'sh0001, 16'sh1000, 16'shF000, 16'sh4000
  };

  // -------------------------------------------------------------------------
  // scoreboard: forecasts the polar result of each accepted operand item and
  // checks result items against the oldest forecast
  // -------------------------------------------------------------------------
  class polar_checker;
    polar_t awaited_products [$];
    int     mismatches = 0;

    // clip to signed 32 bits
    function longint clip32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function polar_t predict_polar(part_t a, part_t b, part_t c, part_t d);
      longint      re;
      longint      im;
      longint      x;
      longint      y;
      longint      z;
      longint      xs;
      longint      ys;
      longint      ph;
      logic [63:0] ux;
      logic [63:0] m;
      int          k;
      polar_t      r;
      // with 16-bit q4.12 operands the exact product is already q8.24
      re = clip32(longint'(a) * longint'(c) - longint'(b) * longint'(d));
      im = clip32(longint'(a) * longint'(d) + longint'(b) * longint'(c));
      r.re  = re[31:0];
      r.im  = im[31:0];
      r.mag = '0;
      r.ph  = '0;
      if (re != 0 || im != 0) begin
        x = re <<< GUARD_BITS;
        y = im <<< GUARD_BITS;
        z = 0;
        // left half plane: pre-rotate by pi
        if (x < 0) begin
          z = (y >= 0) ? longint'(PI_Q30) : -longint'(PI_Q30);
          x = -x;
          y = -y;
        end
        for (k = 0; k < STEPS; k++) begin
          xs = x >>> k;
          ys = y >>> k;
          if (y > 0) begin
            x = x + ys;
            y = y - xs;
            z = z + longint'(ARCTAN_Q30[k]);
          end else begin
            x = x - ys;
            y = y + xs;
            z = z - longint'(ARCTAN_Q30[k]);
          end
        end
        if (x > 0) begin
          ux = x;
          m  = (ux * 64'(GAIN_Q24) + (64'd1 << (23 + GUARD_BITS))) >> (24 + GUARD_BITS);
          r.mag = (m > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : m[31:0];
        end
        ph = (z + 64'sd65536) >>> 17;
        if (ph > longint'(PHASE_LIMIT)) ph = longint'(PHASE_LIMIT);
        if (ph < -longint'(PHASE_LIMIT)) ph = -longint'(PHASE_LIMIT);
        r.ph = ph[15:0];
      end
      return r;
    endfunction

    function void note_operands(part_t a, part_t b, part_t c, part_t d);
      awaited_products.push_back(predict_polar(a, b, c, d));
    endfunction

    function void check_product(polar_t got);
      polar_t want;
      if (awaited_products.size() == 0) begin
        mismatches++;
        if (mismatches <= MISMATCH_SHOWN)
          $display("unexpected result item: re=%0d im=%0d mag=%0d ph=%0d",
                   got.re, got.im, got.mag, got.ph);
        return;
      end
      want = awaited_products.pop_front();
      if (got.re !== want.re || got.im !== want.im ||
          got.mag !== want.mag || got.ph !== want.ph) begin
        mismatches++;
        if (mismatches <= MISMATCH_SHOWN)
          $display({"result mismatch: expected re=%0d im=%0d mag=%0d ph=%0d,",
                    " got re=%0d im=%0d mag=%0d ph=%0d"},
                   want.re, want.im, want.mag, want.ph,
                   got.re, got.im, got.mag, got.ph);
      end
    endfunction
  endclass

  logic clk;
  logic rst;

  cmp_in_if #(.WIDTH(OPW)) op_ch ();
  cmp_out_if               res_ch ();

  complex_multiply_polar #(
    .OPERAND_WIDTH(OPW),
    .CORDIC_STEPS (STEPS)
  ) uut (
    .clk     (clk),
    .rst     (rst),
    .operands(op_ch),
    .results (res_ch)
  );

  polar_checker book = new();

  // idle chances in percent, set per phase by the main sequence
  int send_idle = 0;
  int recv_idle = 0;
  // asks the receiver for one long hold-off
  bit stall_armed = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // -------------------------------------------------------------------------
  // operand side
  // -------------------------------------------------------------------------

  // offer one operand item and wait until it is taken; valid is left high so
  // back to back items need no second assignment in the same step
  task automatic send_item(input part_t a, input part_t b, input part_t c, input part_t d);
    while ($urandom_range(99) < send_idle) begin
      op_ch.valid <= 1'b0;
      @(posedge clk);
    end
    op_ch.valid       <= 1'b1;
    op_ch.first_real  <= a;
    op_ch.first_imag  <= b;
    op_ch.second_real <= c;
    op_ch.second_imag <= d;
    @(posedge clk);
    while (!op_ch.ready) @(posedge clk);
    book.note_operands(a, b, c, d);
  endtask

  // mostly full range, some small and tiny values, some range corners
  function automatic part_t rand_part();
    int pick;
    pick = $urandom_range(9);
    if (pick <= 5) return part_t'($urandom_range(65535));
    if (pick <= 7) return part_t'(int'($urandom_range(8192)) - 4096);
    if (pick == 8) return part_t'(int'($urandom_range(16)) - 8);
    return CORNER_VALUES[$urandom_range(7)];
  endfunction

  task automatic send_random_batch(input int count);
    part_t a;
    part_t b;
    part_t c;
    part_t d;
    for (int n = 0; n < count; n++) begin
      a = rand_part();
      b = rand_part();
      c = rand_part();
      d = rand_part();
      case ($urandom_range(9))
        // conjugate pair: product on the positive real axis
        6: begin
          c = a;
          d = -b;
        end
        // product on the negative real axis, phase near pi
        7: begin
          c = -a;
          d = b;
        end
        // one operand zero: zero product
        8: begin
          if ($urandom_range(1)) begin
            c = '0;
            d = '0;
          end else begin
            a = '0;
            b = '0;
          end
        end
        default: ;
      endcase
      send_item(a, b, c, d);
    end
  endtask

  // -------------------------------------------------------------------------
  // result side: checks at each edge, then picks ready for the next one
  // -------------------------------------------------------------------------
  initial begin
    int     stall_left;
    polar_t got;
    stall_left   = 0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && res_ch.valid && res_ch.ready) begin
        got.re  = res_ch.product_real;
        got.im  = res_ch.product_imag;
        got.mag = res_ch.magnitude;
        got.ph  = res_ch.phase_angle;
        book.check_product(got);
      end
      // long hold-off so the pipeline fills and backs up into the input
      if (stall_left > 0) begin
        stall_left--;
        res_ch.ready <= 1'b0;
      end else if (stall_armed) begin
        stall_armed  = 1'b0;
        stall_left   = STALL_CYCLES;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  // -------------------------------------------------------------------------
  // watchdog: too long without any handshake ends the run
  // -------------------------------------------------------------------------
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((op_ch.valid && op_ch.ready) || (res_ch.valid && res_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("complex_multiply_polar_tb NOT OK");
    $finish;
  end

  // -------------------------------------------------------------------------
  // main sequence
  // -------------------------------------------------------------------------
  initial begin
    rst               <= 1'b1;
    op_ch.valid       <= 1'b0;
    op_ch.first_real  <= '0;
    op_ch.first_imag  <= '0;
    op_ch.second_real <= '0;
    op_ch.second_imag <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // sender mostly busy, receiver mostly idle
    send_idle = 7;
    recv_idle = 88;

    // directed items
    send_item(16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000); // zero product, all zero
    send_item(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000); // most negative everywhere
    send_item(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF); // imag just under full scale
    send_item(16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh7FFF); // real just under full scale
    send_item(16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF); // real near negative full scale
    send_item(16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh8000); // mixed corners
    send_item(16'sh8000, 16'sh0000, 16'sh8000, 16'sh0000); // large positive real
    send_item(16'sh1000, 16'sh0000, 16'sh1000, 16'sh0000); // one times one
    send_item(16'shF000, 16'sh0000, 16'sh1000, 16'sh0000); // negative real axis
    send_item(16'shF000, 16'shFFFF, 16'sh1000, 16'sh0000); // just below negative axis
    send_item(16'shFFFF, 16'sh0000, 16'sh0001, 16'sh0000); // tiny negative real
    send_item(16'sh0000, 16'sh1000, 16'sh1000, 16'sh0000); // positive imag axis
    send_item(16'sh0000, 16'shF000, 16'sh1000, 16'sh0000); // negative imag axis
    send_item(16'sh0001, 16'sh0000, 16'sh0001, 16'sh0000); // smallest nonzero
    send_item(16'sh0001, 16'sh0001, 16'sh0001, 16'sh0000); // tiny diagonal
    send_item(16'sh0000, 16'sh0001, 16'sh0000, 16'sh0001); // j times j
    send_item(16'sh0001, 16'shFFFF, 16'shFFFF, 16'sh0001); // tiny, imag only
    send_item(16'sh0000, 16'sh0000, 16'sh7FFF, 16'sh8000); // zero first operand
    send_item(16'sh7FFF, 16'sh0000, 16'sh0000, 16'sh0000); // zero second operand
    send_item(16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000); // imag near negative full scale
    send_item(16'sh4000, 16'shC000, 16'shC000, 16'sh4000); // large positive imag axis

    send_random_batch(ITEMS_PER_RUN);

    // sender mostly idle, receiver mostly busy
    send_idle = 88;
    recv_idle = 7;
    send_random_batch(ITEMS_PER_RUN);

    // full rate, with one long receiver hold-off while items keep coming
    send_idle   = 0;
    recv_idle   = 0;
    stall_armed = 1'b1;
    send_random_batch(ITEMS_PER_RUN);
    op_ch.valid <= 1'b0;

    // drain, then watch a while longer for stray result items
    while (book.awaited_products.size() != 0) @(posedge clk);
    repeat (2 * LATENCY) @(posedge clk);

    if (book.mismatches == 0 && book.awaited_products.size() == 0) begin
      $display("complex_multiply_polar_tb OK");
    end else begin
      $display("complex_multiply_polar_tb NOT OK");
    end
    $finish;
  end

endmodule
